>>> hdl/psc_pkg.sv
`default_nettype none

package psc_pkg;

   // Register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_X     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_Y     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTOR_COUNT = 2'd2;
   localparam logic [6:0] SECTOR_COUNT_RESET = 7'd8;

   // Parameter defaults
   localparam int MAX_SECTORS_DEFAULT   = 64;
   localparam int CORDIC_STAGES_DEFAULT = 20;

   // Datapath widths and constants
   localparam int SQRT_STEPS = 25;              // one root bit per cell
   localparam int SQ_W       = 33;              // dx^2 + dy^2
   localparam int REM_W      = 26;
   localparam int ROOT_W     = 25;
   localparam int CORDIC_W   = 36;              // x, y: coordinate << 16 plus gain
   localparam int Z_W        = 34;              // angle accumulator, 2^-23 degree
   localparam logic signed [Z_W-1:0] Z_HALF = 34'sd1509949440;   // 180 degrees
   localparam logic signed [Z_W-1:0] Z_FULL = 34'sd3019898880;   // 360 degrees
   localparam logic [16:0] FULL_TURN = 17'd46080;                // 360 deg, 1/128 deg
   localparam int SECT_PRE_SHIFT = 10;          // 46080 = 45 << 10
   localparam int M_W            = 15;
   localparam int MQ_W           = 31;
   localparam logic [15:0] RECIP_45 = 16'd46604; // ceil(2^21 / 45), exact for m < 74898
   localparam int RECIP_SHIFT    = 21;

   typedef struct packed {
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
      logic [15:0]        vertex_id;
      logic               is_center;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic [15:0] point_id;
      logic        placed;
      logic [24:0] radius;
      logic [15:0] angle;
      logic [5:0]  sector;
      logic        sweep_end;
   } rsp_type;

   typedef struct packed {
      logic [15:0] vertex_id;
      logic        is_center;
      logic        last_point;
   } tag_type;

   typedef struct packed {
      tag_type                    tag;
      logic                       zero;
      logic [SQ_W-1:0]            sq;
      logic [REM_W-1:0]           rem;
      logic [ROOT_W-1:0]          root;
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [Z_W-1:0]      z;
   } cell_data_type;

   typedef struct packed {
      tag_type     tag;
      logic [24:0] radius;
      logic [15:0] angle;
   } tail_data_type;

   // atan(2^-i) in 2^-23 degree, rounded
   function automatic logic signed [Z_W-1:0] atan_lut(input int unsigned idx);
      logic signed [Z_W-1:0] v;
      unique case (idx)
         0:  v = 34'sd377487360;
         1:  v = 34'sd222843801;
         2:  v = 34'sd117744544;
         3:  v = 34'sd59768969;
         4:  v = 34'sd30000467;
         5:  v = 34'sd15014858;
         6:  v = 34'sd7509261;
         7:  v = 34'sd3754860;
         8:  v = 34'sd1877459;
         9:  v = 34'sd938733;
         10: v = 34'sd469367;
         11: v = 34'sd234683;
         12: v = 34'sd117342;
         13: v = 34'sd58671;
         14: v = 34'sd29335;
         15: v = 34'sd14668;
         16: v = 34'sd7334;
         17: v = 34'sd3667;
         18: v = 34'sd1833;
         19: v = 34'sd917;
         20: v = 34'sd458;
         21: v = 34'sd229;
         22: v = 34'sd115;
         23: v = 34'sd57;
         24: v = 34'sd29;
         25: v = 34'sd14;
         26: v = 34'sd7;
         27: v = 34'sd4;
         28: v = 34'sd2;
         29: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

>>> hdl/psc_front.sv
`default_nettype none

module psc_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  psc_pkg::req_type            in_data,
   input  wire logic signed [15:0]     origin_x,
   input  wire logic signed [15:0]     origin_y,
   output logic                        out_valid,
   output psc_pkg::cell_data_type      out_data
);
   import psc_pkg::*;

   // stage 1: offsets
   logic               s1_valid_ff;
   tag_type            s1_tag_ff;
   logic signed [16:0] s1_dx_ff, s1_dy_ff;
   logic signed [16:0] s1_dx_in, s1_dy_in;

   // stage 2: squares
   logic               s2_valid_ff;
   tag_type            s2_tag_ff;
   logic signed [16:0] s2_dx_ff, s2_dy_ff;
   logic [31:0]        s2_dxx_ff, s2_dyy_ff;
   logic signed [33:0] dxx_full, dyy_full;

   // stage 3: sum and CORDIC start vector
   logic               s3_valid_ff;
   cell_data_type      s3_data_ff, s3_data_in;
   logic signed [16:0] ax, ay;
   logic               dx_neg;

   assign s1_dx_in = {in_data.point_x[15], in_data.point_x} - {origin_x[15], origin_x};
   assign s1_dy_in = {in_data.point_y[15], in_data.point_y} - {origin_y[15], origin_y};

   assign dxx_full = s1_dx_ff * s1_dx_ff;
   assign dyy_full = s1_dy_ff * s1_dy_ff;

   // left half plane: rotate by 180 degrees first
   assign dx_neg = s2_dx_ff[16];
   assign ax     = dx_neg ? -s2_dx_ff : s2_dx_ff;
   assign ay     = dx_neg ? -s2_dy_ff : s2_dy_ff;

   always_comb begin
      s3_data_in      = '0;
      s3_data_in.tag  = s2_tag_ff;
      s3_data_in.zero = (s2_dx_ff == '0) && (s2_dy_ff == '0);
      s3_data_in.sq   = {1'b0, s2_dxx_ff} + {1'b0, s2_dyy_ff};
      s3_data_in.x    = {{3{ax[16]}}, ax, 16'b0};
      s3_data_in.y    = {{3{ay[16]}}, ay, 16'b0};
      s3_data_in.z    = dx_neg ? Z_HALF : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_tag_ff  <= '{vertex_id: in_data.vertex_id, is_center: in_data.is_center,
                         last_point: in_data.last_point};
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
         s2_tag_ff  <= s1_tag_ff;
         s2_dx_ff   <= s1_dx_ff;
         s2_dy_ff   <= s1_dy_ff;
         s2_dxx_ff  <= dxx_full[31:0];
         s2_dyy_ff  <= dyy_full[31:0];
         s3_data_ff <= s3_data_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_data  = s3_data_ff;

endmodule

`default_nettype wire

>>> hdl/psc_cell.sv
`default_nettype none

// One step of the chain: one root bit of the square root and/or one CORDIC rotation, as DO_SQRT and DO_CORDIC select.
module psc_cell #(
   parameter int INDEX     = 0,
   parameter bit DO_CORDIC = 1'b1,
   parameter bit DO_SQRT   = 1'b1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  psc_pkg::cell_data_type      in_data,
   output logic                        out_valid,
   output psc_pkg::cell_data_type      out_data
);
   import psc_pkg::*;

   logic                       valid_ff;
   cell_data_type              data_ff, data_in;
   logic [REM_W-1:0]           rem_next;
   logic [ROOT_W-1:0]          root_next;
   logic signed [CORDIC_W-1:0] x_next, y_next;
   logic signed [Z_W-1:0]      z_next;

   generate
      if (DO_SQRT) begin : g_sqrt
         localparam int PAIR_LO = 48 - 2 * INDEX;
         logic [49:0] radicand;
         logic [27:0] r_sh, trial, diff;
         logic        take;
         assign radicand  = {1'b0, in_data.sq, 16'b0};
         assign r_sh      = {in_data.rem, radicand[PAIR_LO +: 2]};
         assign trial     = {1'b0, in_data.root, 2'b01};
         assign diff      = r_sh - trial;
         assign take      = (r_sh >= trial);
         assign rem_next  = take ? diff[REM_W-1:0] : r_sh[REM_W-1:0];
         assign root_next = {in_data.root[ROOT_W-2:0], take};
      end else begin : g_no_sqrt
         assign rem_next  = in_data.rem;
         assign root_next = in_data.root;
      end

      if (DO_CORDIC) begin : g_cordic
         logic signed [CORDIC_W-1:0] x_cur, y_cur, xs, ys;
         logic signed [Z_W-1:0]      z_cur, step;
         assign x_cur = in_data.x;
         assign y_cur = in_data.y;
         assign z_cur = in_data.z;
         assign xs    = x_cur >>> INDEX;
         assign ys    = y_cur >>> INDEX;
         assign step  = atan_lut(INDEX);
         // rotate toward y = 0
         assign x_next = y_cur[CORDIC_W-1] ? x_cur - ys : x_cur + ys;
         assign y_next = y_cur[CORDIC_W-1] ? y_cur + xs : y_cur - xs;
         assign z_next = y_cur[CORDIC_W-1] ? z_cur - step : z_cur + step;
      end else begin : g_no_cordic
         assign x_next = in_data.x;
         assign y_next = in_data.y;
         assign z_next = in_data.z;
      end
   endgenerate

   always_comb begin
      data_in      = in_data;
      data_in.rem  = rem_next;
      data_in.root = root_next;
      data_in.x    = x_next;
      data_in.y    = y_next;
      data_in.z    = z_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> hdl/psc_tail.sv
`default_nettype none

// Angle wrap and rounding, then sector = (angle * n - 1) / 46080.
module psc_tail #(
   parameter int MAX_SECTORS = psc_pkg::MAX_SECTORS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   en,
   input  wire logic                   in_valid,
   input  psc_pkg::cell_data_type      in_data,
   input  wire logic [6:0]             sector_count,
   output logic                        out_valid,
   output psc_pkg::rsp_type            out_data
);
   import psc_pkg::*;

   localparam int SECTOR_W = $clog2(MAX_SECTORS + 1);
   localparam int PROD_W   = 16 + SECTOR_W;

   logic [4:0] valid_ff;

   // T1
   tail_data_type         t1_ff, t1_in;
   logic                  t1_zero_ff;
   logic [31:0]           t1_zw_ff;
   logic signed [Z_W-1:0] zw;
   // T2
   tail_data_type         t2_ff, t2_in;
   logic [32:0]           rounded;
   logic [16:0]           a_raw;
   // T3
   tail_data_type         t3_ff;
   logic [PROD_W-1:0]     t3_prod_ff, prod_in;
   logic [SECTOR_W-1:0]   n_sect;
   // T4
   tail_data_type         t4_ff;
   logic [M_W-1:0]        t4_m_ff, m_in;
   logic [PROD_W-1:0]     prod_m1;
   // T5
   tail_data_type         t5_ff;
   logic [MQ_W-1:0]       t5_mq_ff, mq_in;

   always_comb begin
      if (in_data.z < 0) begin
         zw = in_data.z + Z_FULL;
      end else if (in_data.z >= Z_FULL) begin
         zw = in_data.z - Z_FULL;
      end else begin
         zw = in_data.z;
      end
      t1_in        = '0;
      t1_in.tag    = in_data.tag;
      t1_in.radius = in_data.tag.is_center ? '0 : in_data.root;
   end

   // round to nearest 1/128 degree, ties up; a full turn wraps to 0
   assign rounded = {1'b0, t1_zw_ff} + 33'd32768;
   assign a_raw   = rounded[32:16];
   always_comb begin
      t2_in = t1_ff;
      if (t1_zero_ff || t1_ff.tag.is_center || (a_raw >= FULL_TURN)) begin
         t2_in.angle = '0;
      end else begin
         t2_in.angle = a_raw[15:0];
      end
   end

   always_comb begin
      if (sector_count == '0) begin
         n_sect = SECTOR_W'(1);
      end else if (32'(sector_count) > MAX_SECTORS) begin
         n_sect = SECTOR_W'(MAX_SECTORS);
      end else begin
         n_sect = SECTOR_W'(sector_count);
      end
   end
   assign prod_in = PROD_W'(t2_ff.angle) * PROD_W'(n_sect);

   assign prod_m1 = t3_prod_ff - PROD_W'(1);
   assign m_in    = (t3_prod_ff == '0) ? '0 : M_W'(prod_m1 >> SECT_PRE_SHIFT);

   // divide by 45 through the reciprocal
   assign mq_in = MQ_W'(t4_m_ff) * MQ_W'(RECIP_45);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff      <= t1_in;
         t1_zero_ff <= in_data.zero;
         t1_zw_ff   <= zw[31:0];
         t2_ff      <= t2_in;
         t3_ff      <= t2_ff;
         t3_prod_ff <= prod_in;
         t4_ff      <= t3_ff;
         t4_m_ff    <= m_in;
         t5_ff      <= t4_ff;
         t5_mq_ff   <= mq_in;
      end
   end

   assign out_valid          = valid_ff[4];
   assign out_data.point_id  = t5_ff.tag.vertex_id;
   assign out_data.placed    = ~t5_ff.tag.is_center;
   assign out_data.radius    = t5_ff.radius;
   assign out_data.angle     = t5_ff.angle;
   assign out_data.sector    = t5_mq_ff[RECIP_SHIFT +: 6];
   assign out_data.sweep_end = t5_ff.tag.last_point;

endmodule

`default_nettype wire

>>> hdl/polar_sector_classifier.sv
// polar_sector_classifier
//
// Streams points in on req_* and gives one beat on rsp_* per point, in order:
// id, distance from the origin (1/256 unit), angle (1/128 degree), sector.
// Origin and sector count are set through csr_* (index 0 origin_x, 1 origin_y,
// 2 sector_count); csr_ready is always high, write only while the block is idle.
//
// Throughput: one beat per cycle while the skid is empty. A req beat passes
// through 3 front stages (offset, squares, sum), the cell chain of
// max(25, CORDIC_STAGES) cells (one root bit and/or one CORDIC rotation
// per cell; the 25 root bits set the floor), 5 tail stages (angle wrap,
// rounding, sector multiply, reciprocal divide) and the output register.
// Stall: the output register has a one-beat skid behind it. req_ready drops
// only while the skid is full, and the whole pipeline holds until it drains.
// Reset: pipeline, skid and output emptied; origin 0, sector_count 8.
`default_nettype none

module polar_sector_classifier #(
   parameter int MAX_SECTORS   = psc_pkg::MAX_SECTORS_DEFAULT,
   parameter int CORDIC_STAGES = psc_pkg::CORDIC_STAGES_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  psc_pkg::req_type                       req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output psc_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [psc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [psc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import psc_pkg::*;

   localparam int N_CELLS = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

   // registers
   logic signed [15:0] origin_x_ff, origin_x_in;
   logic signed [15:0] origin_y_ff, origin_y_in;
   logic [6:0]         sector_count_ff, sector_count_in;

   // pipeline
   logic               en;
   cell_data_type      chain_data [N_CELLS+1];
   logic [N_CELLS:0]   chain_valid;
   logic               pipe_valid;
   rsp_type            pipe_data;

   // output register + skid
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;
   logic               skid_valid_ff, skid_valid_in;
   rsp_type            skid_data_ff, skid_data_in;
   logic               pipe_take;

   // ---- configuration
   assign csr_ready = 1'b1;

   always_comb begin
      origin_x_in     = origin_x_ff;
      origin_y_in     = origin_y_ff;
      sector_count_in = sector_count_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ORIGIN_X:     origin_x_in     = csr_data;
            CSR_ORIGIN_Y:     origin_y_in     = csr_data;
            CSR_SECTOR_COUNT: sector_count_in = csr_data[6:0];
            default: ;        // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff     <= '0;
         origin_y_ff     <= '0;
         sector_count_ff <= SECTOR_COUNT_RESET;
      end else begin
         origin_x_ff     <= origin_x_in;
         origin_y_ff     <= origin_y_in;
         sector_count_ff <= sector_count_in;
      end
   end

   // ---- datapath; everything advances while the skid is empty
   assign en        = ~skid_valid_ff;
   assign req_ready = en;

   psc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .origin_x  (origin_x_ff),
      .origin_y  (origin_y_ff),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
      psc_cell #(
         .INDEX     (g),
         .DO_CORDIC (g < CORDIC_STAGES),
         .DO_SQRT   (g < SQRT_STEPS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (chain_valid[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   psc_tail #(
      .MAX_SECTORS (MAX_SECTORS)
   ) u_tail (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (chain_valid[N_CELLS]),
      .in_data      (chain_data[N_CELLS]),
      .sector_count (sector_count_ff),
      .out_valid    (pipe_valid),
      .out_data     (pipe_data)
   );

   // ---- output register with skid
   assign pipe_take = pipe_valid & en;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (~rsp_valid_ff | rsp_ready) begin
         // output slot free: skid first, else the pipeline end
         rsp_valid_in  = skid_valid_ff | pipe_take;
         rsp_data_in   = skid_valid_ff ? skid_data_ff : pipe_data;
         skid_valid_in = 1'b0;
      end else if (pipe_take) begin
         skid_valid_in = 1'b1;
         skid_data_in  = pipe_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> hdl/psc_checker.sv
`default_nettype none

module psc_checker (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_ready,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input psc_pkg::rsp_type  rsp_data
);
   import psc_pkg::*;

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed under stall");

   // input side only backs up when a beat is waiting at the output
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req_ready low with empty output");

   // centre point carries no geometry
   a_centre_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.placed |->
         rsp_data.radius == '0 && rsp_data.angle == '0 && rsp_data.sector == '0)
      else $error("centre point with nonzero fields");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_data.angle} < FULL_TURN))
      else $error("angle not below a full turn");

endmodule

bind polar_sector_classifier psc_checker u_psc_checker (.*);

`default_nettype wire

>>> bench/polar_sector_checker.sv
// Watches the three channels, keeps its own copy of the register file and
// predicts one result beat per accepted point. Result beats are checked in
// order against the oldest prediction.
module polar_sector_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  psc_pkg::req_type                  req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  psc_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [psc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [psc_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                mismatches,
   output int                                outstanding
);

   localparam int          SECTOR_CAP = 64;
   localparam int          ROTATIONS  = 20;
   localparam longint      DEG_UNIT   = 64'd8388608;     // 2^23 per degree
   localparam longint      TURN_Z     = 360 * DEG_UNIT;
   localparam longint      TURN_ANGLE = 46080;           // 360 deg in 1/128 deg
   localparam longint unsigned RADIUS_SAT = 64'h1FF_FFFF;

   logic signed [15:0] org_x;
   logic signed [15:0] org_y;
   logic [6:0]         sectors;
   psc_pkg::rsp_type   placed_points[$];

   // atan(2^-i) in 2^-23 degree
   function automatic longint arctan_step(input int i);
      case (i)
         0:  return 377487360;
         1:  return 222843801;
         2:  return 117744544;
         3:  return 59768969;
         4:  return 30000467;
         5:  return 15014858;
         6:  return 7509261;
         7:  return 3754860;
         8:  return 1877459;
         9:  return 938733;
         10: return 469367;
         11: return 234683;
         12: return 117342;
         13: return 58671;
         14: return 29335;
         15: return 14668;
         16: return 7334;
         17: return 3667;
         18: return 1833;
         19: return 917;
         20: return 458;
         21: return 229;
         22: return 115;
         23: return 57;
         24: return 29;
         25: return 14;
         26: return 7;
         27: return 4;
         28: return 2;
         29: return 1;
         default: return 0;
      endcase
   endfunction

   function automatic longint unsigned floor_root(input longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n)
         bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // vectoring rotation; >>> on longint floors toward minus infinity
   function automatic logic [15:0] cordic_angle(input longint dx, input longint dy);
      longint x, y, z, xs, ys;
      if (dx == 0 && dy == 0)
         return '0;
      if (dx < 0) begin
         x = -dx * 65536;
         y = -dy * 65536;
         z = 180 * DEG_UNIT;
      end else begin
         x = dx * 65536;
         y = dy * 65536;
         z = 0;
      end
      for (int i = 0; i < ROTATIONS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + arctan_step(i);
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - arctan_step(i);
         end
      end
      while (z < 0)
         z += TURN_Z;
      while (z >= TURN_Z)
         z -= TURN_Z;
      z = (z + 32768) >>> 16;
      if (z >= TURN_ANGLE)
         z -= TURN_ANGLE;
      return z[15:0];
   endfunction

   function automatic psc_pkg::rsp_type classify_point(input psc_pkg::req_type p);
      psc_pkg::rsp_type r;
      longint dx, dy;
      longint unsigned rt, prod, q;
      int unsigned n;
      r = '0;
      r.point_id  = p.vertex_id;
      r.sweep_end = p.last_point;
      r.placed    = !p.is_center;
      if (!p.is_center) begin
         dx = longint'(p.point_x) - longint'(org_x);
         dy = longint'(p.point_y) - longint'(org_y);
         rt = floor_root(longint'(dx * dx + dy * dy) << 16);
         if (rt > RADIUS_SAT)
            rt = RADIUS_SAT;
         r.radius = rt[24:0];
         r.angle  = cordic_angle(dx, dy);
         n = (sectors == 0) ? 1 : (sectors > SECTOR_CAP) ? SECTOR_CAP : sectors;
         prod = 64'(r.angle) * 64'(n);
         q = (prod == 0) ? 0 : (prod - 1) / TURN_ANGLE;
         r.sector = q[5:0];
      end
      return r;
   endfunction

   function automatic int differs(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch
      int errs;
      psc_pkg::rsp_type want;
      errs = 0;
      if (reset) begin
         org_x   <= '0;
         org_y   <= '0;
         sectors <= 7'd8;
         placed_points.delete();
         mismatches  <= 0;
         outstanding <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               psc_pkg::CSR_ORIGIN_X:     org_x   <= csr_data;
               psc_pkg::CSR_ORIGIN_Y:     org_y   <= csr_data;
               psc_pkg::CSR_SECTOR_COUNT: sectors <= csr_data[6:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            placed_points.push_back(classify_point(req_data));
         if (rsp_valid && rsp_ready) begin
            if (placed_points.size() == 0) begin
               $display("%0t: result beat with nothing pending, actual %h", $time, rsp_data);
               errs = 1;
            end else begin
               want = placed_points.pop_front();
               errs = differs("point_id", want.point_id, rsp_data.point_id)
                    + differs("placed", want.placed, rsp_data.placed)
                    + differs("radius", want.radius, rsp_data.radius)
                    + differs("angle", want.angle, rsp_data.angle)
                    + differs("sector", want.sector, rsp_data.sector)
                    + differs("sweep_end", want.sweep_end, rsp_data.sweep_end);
            end
         end
         mismatches  <= mismatches + errs;
         outstanding <= placed_points.size();
      end
   end

endmodule

>>> bench/tb_polar_sector_classifier.sv
// Stimulus and verdict for the polar sector classifier. Prediction and
// comparison live in polar_sector_checker, instantiated beside the DUT.
module tb_polar_sector_classifier;

   // The pipeline is 34 deep with default parameters; give it some margin.
   localparam int SETTLE_CYCLES = 60;
   // A correct run ends long before this limit, even with heavy idling.
   localparam int CYCLE_LIMIT   = 300000;
   localparam int PHASE_POINTS  = 104;
   localparam logic [psc_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_ready;
   psc_pkg::req_type                  req_data  = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   psc_pkg::rsp_type                  rsp_data;
   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [psc_pkg::CSR_INDEX_W-1:0]   csr_index = '0;
   logic [psc_pkg::CSR_DATA_W-1:0]    csr_data  = '0;

   // Idle odds in percent, changed per phase.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatches;
   int outstanding;
   int cycles = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   polar_sector_classifier DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   polar_sector_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Receiver back-pressure: a fresh coin every cycle.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("polar_sector_classifier verification failed");
         $finish;
      end
   end

   // Ready is sampled at the falling edge, where it is settled, so the
   // handshake never depends on event order at the rising edge. Valid stays
   // high on return; the caller drops it after the last beat.
   task automatic write_csr(input logic [psc_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [psc_pkg::CSR_DATA_W-1:0] val);
      logic taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Optional idle gap first, then hold the beat until it is taken.
   task automatic send_point(input psc_pkg::req_type p);
      logic taken;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Wait for every predicted beat to come back, then let the pipe settle.
   task automatic drain(input int settle);
      do @(negedge clock); while (outstanding != 0);
      repeat (settle) @(posedge clock);
   endtask

   // Mostly uniform; some extremes, and some points hugging the origin so
   // that axis and sector boundaries get hit.
   function automatic logic [15:0] pick_coord(input logic [15:0] centre);
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(4))
               0:       return 16'h8000;
               1:       return 16'hFFFF;
               2:       return 16'h0000;
               3:       return 16'h0001;
               default: return 16'h7FFF;
            endcase
         end
         1:       return centre + 16'($urandom_range(6)) - 16'd3;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic psc_pkg::req_type random_point(input logic [15:0] ox,
                                                     input logic [15:0] oy);
      psc_pkg::req_type p;
      p.point_x = pick_coord(ox);
      p.point_y = pick_coord(oy);
      // occasional diagonal through the origin: eighths of the circle
      case ($urandom_range(19))
         0: p.point_y = oy + (p.point_x - ox);
         1: p.point_y = oy - (p.point_x - ox);
         default: ;
      endcase
      p.vertex_id  = 16'($urandom);
      p.is_center  = ($urandom_range(9) == 0);
      // sweeps of random length, closed by last_point
      p.last_point = ($urandom_range(7) == 0);
      return p;
   endfunction

   initial begin
      psc_pkg::req_type pt;
      logic [15:0] ox, oy;
      logic [6:0]  count_raw;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset setting (origin 0, eight sectors), no idling.
      // Axes, quadrant diagonals, full-scale corners, near-wrap angles on
      // both sides of the x axis, a point on the origin, centre beats.
      for (int d = 0; d < 22; d++) begin
         case (d)
            0:  begin pt.point_x = 16'sd0;      pt.point_y = 16'sd0;      end
            1:  begin pt.point_x = 16'sd1;      pt.point_y = 16'sd0;      end
            2:  begin pt.point_x = 16'sd0;      pt.point_y = 16'sd1;      end
            3:  begin pt.point_x = -16'sd1;     pt.point_y = 16'sd0;      end
            4:  begin pt.point_x = 16'sd0;      pt.point_y = -16'sd1;     end
            5:  begin pt.point_x = 16'sd1;      pt.point_y = 16'sd1;      end
            6:  begin pt.point_x = -16'sd1;     pt.point_y = 16'sd1;      end
            7:  begin pt.point_x = -16'sd1;     pt.point_y = -16'sd1;     end
            8:  begin pt.point_x = 16'sd1;      pt.point_y = -16'sd1;     end
            9:  begin pt.point_x = 16'sh7FFF;   pt.point_y = 16'sd0;      end
            10: begin pt.point_x = 16'sh8000;   pt.point_y = 16'sd0;      end
            11: begin pt.point_x = 16'sd0;      pt.point_y = 16'sh7FFF;   end
            12: begin pt.point_x = 16'sd0;      pt.point_y = 16'sh8000;   end
            13: begin pt.point_x = 16'sh7FFF;   pt.point_y = 16'sh7FFF;   end
            14: begin pt.point_x = 16'sh8000;   pt.point_y = 16'sh8000;   end
            15: begin pt.point_x = 16'sh8000;   pt.point_y = 16'sh7FFF;   end
            16: begin pt.point_x = 16'sh7FFF;   pt.point_y = 16'sh8000;   end
            17: begin pt.point_x = 16'sd30000;  pt.point_y = -16'sd1;     end
            18: begin pt.point_x = -16'sd30000; pt.point_y = 16'sd1;      end
            19: begin pt.point_x = -16'sd30000; pt.point_y = -16'sd1;     end
            default: begin
               pt.point_x = 16'($urandom);
               pt.point_y = (d == 21) ? 16'sd0 : 16'($urandom);
               if (d == 21)
                  pt.point_x = 16'sd0;
            end
         endcase
         pt.vertex_id  = (d == 0) ? 16'h0000 : (d == 1) ? 16'hFFFF : 16'($urandom);
         pt.is_center  = (d >= 20);
         pt.last_point = (d % 5 == 4);
         send_point(pt);
      end
      req_valid <= 1'b0;
      drain(2);

      // Random phases. Each one rewrites the registers while the block is
      // empty, then streams points under one idling pattern.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin ox = 16'h8000; oy = 16'h7FFF; count_raw = 7'd64;  end
            1: begin ox = 16'h7FFF; oy = 16'h8000; count_raw = 7'd1;   end
            2: begin ox = 16'h0000; oy = 16'h0000; count_raw = 7'd0;   end // acts as 1
            3: begin ox = 16'($urandom); oy = 16'($urandom); count_raw = 7'd127; end // capped
            4: begin ox = 16'hFFFF; oy = 16'hFFFF; count_raw = 7'd3;   end
            default: begin
               ox = 16'($urandom);
               oy = 16'($urandom);
               count_raw = 7'($urandom_range(1, 64));
            end
         endcase

         case (ph % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 67; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 67; end
            default: begin send_idle_pct = 9; rsp_stall_pct = 9; end
         endcase

         write_csr(psc_pkg::CSR_ORIGIN_X, ox);
         write_csr(psc_pkg::CSR_ORIGIN_Y, oy);
         // upper data bits are junk; only the low seven count
         write_csr(psc_pkg::CSR_SECTOR_COUNT, {9'($urandom), count_raw});
         if (ph == 2)
            write_csr(CSR_UNUSED, 16'($urandom));   // must be dropped
         csr_valid <= 1'b0;

         for (int k = 0; k < PHASE_POINTS; k++)
            send_point(random_point(ox, oy));
         req_valid <= 1'b0;
         drain(2);
      end

      drain(SETTLE_CYCLES);
      if (mismatches == 0 && outstanding == 0)
         $display("polar_sector_classifier verification clean");
      else
         $display("polar_sector_classifier verification failed");
      $finish;
   end

endmodule
